@@ hw/rtl/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU key/value table.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int ENTRIES_DEFAULT    = 16;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int DATA_BITS          = 32;
   localparam int CAPACITY_BITS      = 5;

   localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 5'd16;
   localparam logic [DATA_BITS-1:0]     MISS_VALUE     = '1;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic plan;
      logic update;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic pass_done;
      logic need_pass;
      logic rsp_free;
   } sts_type;

endpackage

@@ hw/rtl/lfu_if.sv @@
// ----------------------------------------------------------------------------
// lfu_req_if / lfu_rsp_if
// Valid/ready channels for requests and responses of the LFU table.
// ----------------------------------------------------------------------------
interface lfu_req_if import lfu_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [DATA_BITS-1:0] lookup_key;
   logic [DATA_BITS-1:0] write_value;

   modport source (output valid, operation, lookup_key, write_value, input ready);
   modport sink   (input valid, operation, lookup_key, write_value, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [DATA_BITS-1:0] read_value;

   modport source (output valid, hit, read_value, input ready);
   modport sink   (input valid, hit, read_value, output ready);
endinterface

@@ hw/rtl/lfu_ram.sv @@
// ----------------------------------------------------------------------------
// lfu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ hw/rtl/lfu_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept, scan pass, plan, rank update pass when needed, commit.
// ----------------------------------------------------------------------------
module lfu_ctrl import lfu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_PLAN   = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_COMMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.pass_done) state_in = ST_PLAN;
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = sts.need_pass ? ST_UPDATE : ST_COMMIT;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (sts.pass_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = sts.rsp_free;
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ hw/rtl/lfu_datapath.sv @@
// ----------------------------------------------------------------------------
// lfu_datapath
// Entry store, key match and victim tracking, rank rewrite, response register.
// ----------------------------------------------------------------------------
module lfu_datapath import lfu_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic                     csr_we,
   input  logic [CAPACITY_BITS-1:0] csr_wdata,
   input  logic                     req_operation,
   input  logic [DATA_BITS-1:0]     req_lookup_key,
   input  logic [DATA_BITS-1:0]     req_write_value,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic                     rsp_hit,
   output logic [DATA_BITS-1:0]     rsp_read_value
);
   localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW    = $clog2(ENTRIES + 1);
   localparam int RW    = AW;
   localparam int ROW_W = 2 * DATA_BITS + COUNT_BITS + RW;

   logic [CW-1:0]            used_ff, used_in;
   logic [CAPACITY_BITS-1:0] cap_ff, cap_in;
   logic [CW-1:0]            addr_ff, addr_in;
   logic                     rd_pend_ff;
   logic [AW-1:0]            rd_idx_ff;

   logic                     op_ff;
   logic [DATA_BITS-1:0]     key_ff, wval_ff;

   logic                     hit_ff;
   logic [AW-1:0]            hit_idx_ff;
   logic [RW-1:0]            hit_rank_ff;
   logic [COUNT_BITS-1:0]    hit_cnt_ff;
   logic [DATA_BITS-1:0]     hit_val_ff;
   logic                     vic_any_ff;
   logic [AW-1:0]            vic_idx_ff;
   logic [RW-1:0]            vic_rank_ff;
   logic [COUNT_BITS-1:0]    vic_cnt_ff;

   logic [AW-1:0]            tgt_ff;
   logic [RW-1:0]            thr_ff;
   logic                     ins_ff, act_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_hit_ff;
   logic [DATA_BITS-1:0]     rsp_val_ff;

   logic                     issue;
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr;
   logic [ROW_W-1:0]         ram_wdata, ram_rdata;

   logic [DATA_BITS-1:0]     rd_key, rd_val;
   logic [COUNT_BITS-1:0]    rd_cnt, new_cnt;
   logic [RW-1:0]            rd_rank, new_rank;
   logic                     is_put, cap_zero, room;

   assign {rd_key, rd_val, rd_cnt, rd_rank} = ram_rdata;

   assign is_put   = (op_ff == OP_PUT);
   assign cap_zero = (cap_ff == '0);
   assign room     = 32'(used_ff) < 32'(cap_ff);
   assign issue    = (cmd.scan || cmd.update) && (addr_ff < used_ff);

   assign sts.pass_done = (addr_ff >= used_ff) && !rd_pend_ff;
   assign sts.need_pass = hit_ff || (is_put && !cap_zero);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign new_cnt  = !hit_ff ? COUNT_BITS'(1)
                   : (&hit_cnt_ff) ? hit_cnt_ff : hit_cnt_ff + 1'b1;
   assign new_rank = rd_rank + 1'b1;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = rd_idx_ff;
      ram_wdata = ram_rdata;
      if (cmd.commit && act_ff) begin
         ram_we    = 1'b1;
         ram_waddr = tgt_ff;
         ram_wdata = {key_ff, (is_put ? wval_ff : hit_val_ff), new_cnt, RW'(0)};
      end else if (cmd.update && rd_pend_ff && rd_idx_ff != tgt_ff) begin
         ram_we    = 1'b1;
         ram_wdata = {rd_key, rd_val, rd_cnt,
                      ((ins_ff || rd_rank < thr_ff) ? new_rank : rd_rank)};
      end
   end

   lfu_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (issue),
      .raddr (addr_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      cap_in = cap_ff;
      if (csr_we && used_ff == '0) begin
         cap_in = (32'(csr_wdata) > ENTRIES) ? CAPACITY_BITS'(ENTRIES) : csr_wdata;
      end
      used_in = used_ff;
      if (cmd.commit && ins_ff) used_in = used_ff + 1'b1;
      addr_in = addr_ff;
      if (cmd.load || cmd.plan) begin
         addr_in = '0;
      end else if (issue) begin
         addr_in = addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         cap_ff       <= (32'(CAPACITY_RESET) > ENTRIES) ? CAPACITY_BITS'(ENTRIES)
                                                         : CAPACITY_RESET;
         addr_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff    <= used_in;
         cap_ff     <= cap_in;
         addr_ff    <= addr_in;
         rd_pend_ff <= issue;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff[AW-1:0];
      if (cmd.load) begin
         op_ff      <= req_operation;
         key_ff     <= req_lookup_key;
         wval_ff    <= req_write_value;
         hit_ff     <= 1'b0;
         vic_any_ff <= 1'b0;
      end
      if (cmd.scan && rd_pend_ff) begin
         if (!hit_ff && rd_key == key_ff) begin
            hit_ff      <= 1'b1;
            hit_idx_ff  <= rd_idx_ff;
            hit_rank_ff <= rd_rank;
            hit_cnt_ff  <= rd_cnt;
            hit_val_ff  <= rd_val;
         end
         if (!vic_any_ff || rd_cnt < vic_cnt_ff ||
             (rd_cnt == vic_cnt_ff && rd_rank > vic_rank_ff)) begin
            vic_any_ff  <= 1'b1;
            vic_idx_ff  <= rd_idx_ff;
            vic_rank_ff <= rd_rank;
            vic_cnt_ff  <= rd_cnt;
         end
      end
      if (cmd.plan) begin
         act_ff <= sts.need_pass;
         ins_ff <= !hit_ff && is_put && !cap_zero && room;
         thr_ff <= hit_ff ? hit_rank_ff : vic_rank_ff;
         if (hit_ff) begin
            tgt_ff <= hit_idx_ff;
         end else if (room) begin
            tgt_ff <= used_ff[AW-1:0];
         end else begin
            tgt_ff <= vic_idx_ff;
         end
      end
      if (cmd.commit) begin
         rsp_hit_ff <= hit_ff;
         if (is_put) begin
            rsp_val_ff <= '0;
         end else begin
            rsp_val_ff <= hit_ff ? hit_val_ff : MISS_VALUE;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_val_ff;
endmodule

@@ hw/rtl/lfu_cache_table.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key/value table with least-frequently-used replacement, oldest use first
// on equal counts.
//
//   channel   dir   handshake     word
//   req_chan  in    valid/ready   operation, lookup_key, write_value
//   rsp_chan  out   valid/ready   hit, read_value
//   csr       in    csr_we        csr_wdata (capacity_in_use)
//
// A request makes one read pass over the U entries in use for key match and
// victim choice, and one read-modify-write pass for recency ranks, skipped on
// a get miss and on a put at zero capacity; both passes share the single read
// port of the entry RAM.
// Reset is synchronous; the table comes up empty with no clearing pass.
// A stalled response holds in its register while the next request is taken.
// ----------------------------------------------------------------------------
module lfu_cache_table import lfu_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   lfu_req_if.sink                  req_chan,
   lfu_rsp_if.source                rsp_chan,
   input  logic                     csr_we,
   input  logic [CAPACITY_BITS-1:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lfu_datapath #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_operation   (req_chan.operation),
      .req_lookup_key  (req_chan.lookup_key),
      .req_write_value (req_chan.write_value),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_hit         (rsp_chan.hit),
      .rsp_read_value  (rsp_chan.read_value)
   );
endmodule

@@ hw/rtl/lfu_checker.sv @@
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks of the LFU table, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker import lfu_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_hit,
   input logic [DATA_BITS-1:0] rsp_read_value
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_read_value))
      else $error("response word changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while one is in progress");

   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_read_value == MISS_VALUE || rsp_read_value == '0))
      else $error("miss carries a stored value");
endmodule

bind lfu_cache_table lfu_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_hit        (rsp_chan.hit),
   .rsp_read_value (rsp_chan.read_value)
);
